>>> rtl/core/nav_pkg.sv
// ----------------------------------------------------------------------------
// nav_pkg: shared types and constants for the angular vector search
// Angle format, lane count, full-turn constant and register indexes.
// ----------------------------------------------------------------------------
package nav_pkg;

  localparam int LANES       = 6;
  localparam int ANGLE_W     = 15;
  localparam int LDIST_W     = 14;   // one lane distance, at most half a turn
  localparam int DIST_W      = 17;
  localparam int INDEX_W     = 8;
  localparam int CFG_INDEX_W = 3;

  // degrees times 64
  localparam int FULL_TURN   = 23040;
  localparam int HALF_TURN   = FULL_TURN / 2;
  localparam int NUM_JOINTS  = 6;
  localparam int ACTIVE_LANES = (NUM_JOINTS < LANES) ? NUM_JOINTS : LANES;
  localparam int MAX_DIST    = ACTIVE_LANES * HALF_TURN;

  localparam int MAX_CANDIDATES_DEF = 256;

  // register indexes: target angles occupy the first LANES slots
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_0 = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_LAST = CFG_INDEX_W'(LANES - 1);

  typedef logic [ANGLE_W-1:0] angle_t;
  typedef angle_t [LANES-1:0] angle_vec_t;
  typedef logic [LDIST_W-1:0] ldist_t;
  typedef logic [DIST_W-1:0]  dist_t;

endpackage

>>> rtl/core/nav_lane_dist.sv
// ----------------------------------------------------------------------------
// nav_lane_dist: wrapped circular distance of one joint
// Reduces both angles into one turn, takes the forward difference and
// keeps the shorter way round.
// ----------------------------------------------------------------------------
module nav_lane_dist
  import nav_pkg::*;
(
  input  angle_t angle,
  input  angle_t target,
  output ldist_t gap
);

  localparam logic [15:0] TURN = 16'(FULL_TURN);

  logic [15:0] ar, tr, d, e;

  // a 15-bit value is below two turns, so one subtract reduces it
  always_comb begin
    ar = (16'(angle)  >= TURN) ? 16'(angle)  - TURN : 16'(angle);
    tr = (16'(target) >= TURN) ? 16'(target) - TURN : 16'(target);
    d  = (ar >= tr) ? ar - tr : ar + TURN - tr;
    e  = TURN - d;
  end

  assign gap = (d < e) ? LDIST_W'(d) : LDIST_W'(e);

endmodule

>>> rtl/core/nav_dist_sum.sv
// ----------------------------------------------------------------------------
// nav_dist_sum: summed circular distance of a candidate vector
// One lane distance unit per active joint feeding a small adder tree.
// ----------------------------------------------------------------------------
module nav_dist_sum
  import nav_pkg::*;
(
  input  angle_vec_t angles,
  input  angle_vec_t targets,
  output dist_t      sum
);

  ldist_t [ACTIVE_LANES-1:0] lane_d;

  for (genvar g = 0; g < ACTIVE_LANES; g++) begin : g_lane
    nav_lane_dist u_lane (
      .angle  (angles[g]),
      .target (targets[g]),
      .gap    (lane_d[g])
    );
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < ACTIVE_LANES; i++) begin
      sum = sum + DIST_W'(lane_d[i]);
    end
  end

endmodule

>>> rtl/core/nearest_angular_vector_search_unit.sv
// An accepted word goes into the input register and from there updates the search
//   state; a last-marked word also loads the output register that shows the result.
// Throughput: one candidate word per cycle; only a held result word stalls
//   the next last-marked word, set by the single output register.
// Reset: synchronous, active low; clears targets and search state at once.
// ----------------------------------------------------------------------------
// nearest_angular_vector_search_unit: nearest candidate by circular distance
// Streams candidate joint-angle vectors, scores each against the target
// vector and reports the first closest candidate when the search ends.
// ----------------------------------------------------------------------------
module nearest_angular_vector_search_unit
  import nav_pkg::*;
#(
  parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,

  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ANGLE_W-1:0]     cfg_wdata,

  // candidate words
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [ANGLE_W-1:0]     in_angle_0,
  input  logic [ANGLE_W-1:0]     in_angle_1,
  input  logic [ANGLE_W-1:0]     in_angle_2,
  input  logic [ANGLE_W-1:0]     in_angle_3,
  input  logic [ANGLE_W-1:0]     in_angle_4,
  input  logic [ANGLE_W-1:0]     in_angle_5,
  input  logic                   in_last,

  // result words
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [INDEX_W-1:0]     out_best_index,
  output logic [DIST_W-1:0]      out_best_distance,
  output logic [ANGLE_W-1:0]     out_best_angle_0,
  output logic [ANGLE_W-1:0]     out_best_angle_1,
  output logic [ANGLE_W-1:0]     out_best_angle_2,
  output logic [ANGLE_W-1:0]     out_best_angle_3,
  output logic [ANGLE_W-1:0]     out_best_angle_4,
  output logic [ANGLE_W-1:0]     out_best_angle_5,
  output logic                   out_index_overflow
);

  // counter must be able to hold MAX_CANDIDATES itself
  localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_CANDIDATES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CANDIDATES - 1);

  // --------------------------------------------------------------------------
  // Target registers
  // --------------------------------------------------------------------------
  angle_vec_t target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_we && cfg_index >= CFG_TARGET_0 && cfg_index <= CFG_TARGET_LAST) begin
      target_r[cfg_index] <= cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic       s1_valid_r;
  angle_vec_t s1_angles_r;
  logic       s1_last_r;
  logic       s1_adv;
  logic       out_free;
  logic       in_acc;

  // a result word needs the output register; other words always move on
  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_angles_r <= {in_angle_5, in_angle_4, in_angle_3,
                      in_angle_2, in_angle_1, in_angle_0};
      s1_last_r   <= in_last;
    end
  end

  // --------------------------------------------------------------------------
  // Scoring
  // --------------------------------------------------------------------------
  dist_t sum;

  nav_dist_sum u_sum (
    .angles  (s1_angles_r),
    .targets (target_r),
    .sum     (sum)
  );

  // --------------------------------------------------------------------------
  // Running search state
  // --------------------------------------------------------------------------
  dist_t        min_dist_r,  min_dist_nxt;
  logic [INDEX_W-1:0] win_idx_r, win_idx_nxt;
  logic [CNT_W-1:0]   cnt_r,   cnt_nxt;
  logic         sat_r,       sat_nxt;
  logic         have_win_r,  have_win_nxt;
  angle_vec_t   win_ang_r,   win_ang_nxt;
  logic [CNT_W-1:0]   idx;

  always_comb begin
    // counter saturates; late candidates share the final index
    if (cnt_r >= CNT_MAX) begin
      idx     = CNT_LAST;
      sat_nxt = 1'b1;
      cnt_nxt = cnt_r;
    end else begin
      idx     = cnt_r;
      sat_nxt = sat_r;
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    // strictly smaller wins, so ties keep the earlier candidate
    if (!have_win_r || sum < min_dist_r) begin
      have_win_nxt = 1'b1;
      min_dist_nxt = sum;
      win_idx_nxt  = INDEX_W'(idx);
      win_ang_nxt  = s1_angles_r;
    end else begin
      have_win_nxt = have_win_r;
      min_dist_nxt = min_dist_r;
      win_idx_nxt  = win_idx_r;
      win_ang_nxt  = win_ang_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (s1_adv && s1_last_r)) begin
      // fresh search: no candidate yet
      min_dist_r <= '1;
      win_idx_r  <= '0;
      cnt_r      <= '0;
      sat_r      <= 1'b0;
      have_win_r <= 1'b0;
      win_ang_r  <= '0;
    end else if (s1_adv) begin
      min_dist_r <= min_dist_nxt;
      win_idx_r  <= win_idx_nxt;
      cnt_r      <= cnt_nxt;
      sat_r      <= sat_nxt;
      have_win_r <= have_win_nxt;
      win_ang_r  <= win_ang_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register, loaded with the state as it stands after the last word
  // --------------------------------------------------------------------------
  logic               out_valid_r;
  logic [INDEX_W-1:0] out_idx_r;
  dist_t              out_dist_r;
  angle_vec_t         out_ang_r;
  logic               out_ovf_r;
  logic               out_load;

  assign out_load = s1_adv && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= win_idx_nxt;
      out_dist_r <= min_dist_nxt;
      out_ang_r  <= win_ang_nxt;
      out_ovf_r  <= sat_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_best_index     = out_idx_r;
  assign out_best_distance  = out_dist_r;
  assign out_best_angle_0   = out_ang_r[0];
  assign out_best_angle_1   = out_ang_r[1];
  assign out_best_angle_2   = out_ang_r[2];
  assign out_best_angle_3   = out_ang_r[3];
  assign out_best_angle_4   = out_ang_r[4];
  assign out_best_angle_5   = out_ang_r[5];
  assign out_index_overflow = out_ovf_r;

endmodule

>>> rtl/core/nav_checker.sv
// ----------------------------------------------------------------------------
// nav_checker: port-level checks for the angular vector search unit
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module nav_checker
  import nav_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [INDEX_W-1:0]     out_best_index,
  input logic [DIST_W-1:0]      out_best_distance,
  input logic                   out_index_overflow
);

  // a held result word keeps its index, distance and overflow flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_best_index)
      && $stable(out_best_distance) && $stable(out_index_overflow))
    else $error("result word changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word visible after reset");

  // a reported winner is always a real score, never the empty marker
  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_best_distance <= DIST_W'(MAX_DIST))
    else $error("reported distance out of range");

  // a new result word never rises straight out of reset
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(rst_n))
    else $error("result word rose straight out of reset");

  // the input only backs up behind a held result word
  a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled with the result side free");

endmodule

bind nearest_angular_vector_search_unit nav_checker u_nav_checker (.*);

>>> verif/nearest_angular_vector_search_unit_tb.sv
// ----------------------------------------------------------------------------
// nearest_angular_vector_search_unit_tb: self-checking bench for the search unit
// Streams candidate vectors under several target settings, predicts each
// reported winner with a cycle-free scoring model and checks every result
// word field by field, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module nearest_angular_vector_search_unit_tb;
  import nav_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_CAP = 100;
  // a 15-bit angle can sit past a full turn; the top code is the worst case
  localparam int ANGLE_TOP = (1 << ANGLE_W) - 1;
  localparam int LONG_HOLD = 300;
  // index slots above the target bank, written to prove they are ignored
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_6 = CFG_TARGET_LAST + CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_7 = CFG_TARGET_LAST + CFG_INDEX_W'(2);

  typedef struct {
    angle_vec_t ang;
    logic       last;
  } cand_t;

  typedef struct {
    logic [INDEX_W-1:0] index;
    dist_t              distance;
    angle_vec_t         angles;
    logic               overflow;
  } search_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ANGLE_W-1:0]     cfg_wdata = '0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ANGLE_W-1:0] in_angle_0 = '0;
  logic [ANGLE_W-1:0] in_angle_1 = '0;
  logic [ANGLE_W-1:0] in_angle_2 = '0;
  logic [ANGLE_W-1:0] in_angle_3 = '0;
  logic [ANGLE_W-1:0] in_angle_4 = '0;
  logic [ANGLE_W-1:0] in_angle_5 = '0;
  logic               in_last = 1'b0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [INDEX_W-1:0] out_best_index;
  dist_t              out_best_distance;
  logic [ANGLE_W-1:0] out_best_angle_0;
  logic [ANGLE_W-1:0] out_best_angle_1;
  logic [ANGLE_W-1:0] out_best_angle_2;
  logic [ANGLE_W-1:0] out_best_angle_3;
  logic [ANGLE_W-1:0] out_best_angle_4;
  logic [ANGLE_W-1:0] out_best_angle_5;
  logic               out_index_overflow;

  nearest_angular_vector_search_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_angle_0        (in_angle_0),
    .in_angle_1        (in_angle_1),
    .in_angle_2        (in_angle_2),
    .in_angle_3        (in_angle_3),
    .in_angle_4        (in_angle_4),
    .in_angle_5        (in_angle_5),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_best_index    (out_best_index),
    .out_best_distance (out_best_distance),
    .out_best_angle_0  (out_best_angle_0),
    .out_best_angle_1  (out_best_angle_1),
    .out_best_angle_2  (out_best_angle_2),
    .out_best_angle_3  (out_best_angle_3),
    .out_best_angle_4  (out_best_angle_4),
    .out_best_angle_5  (out_best_angle_5),
    .out_index_overflow(out_index_overflow)
  );

  always #5 clk = ~clk;

  // ---- bench state ----
  cand_t          word_q[$];       // candidate words waiting for the driver
  search_result_t results_due[$];  // predicted winners, oldest first
  int unsigned    cycle_count = 0;
  int unsigned    mismatch_count = 0;
  bit             no_idle = 1'b0;       // both sides run flat out
  bit             pressure_on = 1'b0;   // ask the receiver for one long hold-off
  bit             pressure_done = 1'b0;

  // ---- search model: its own copy of the targets and of the running search ----
  angle_vec_t     target_vec = '0;
  int unsigned    best_total;
  int unsigned    winner_slot;
  int unsigned    seen_count;
  bit             count_saturated;
  bit             have_winner;
  angle_vec_t     winner_vec;

  function automatic void restart_search();
    best_total = (1 << DIST_W) - 1;
    winner_slot = 0;
    seen_count = 0;
    count_saturated = 1'b0;
    have_winner = 1'b0;
    winner_vec = '0;
  endfunction

  // shortest way round the circle between two angles, both folded into one turn
  function automatic int unsigned wrapped_gap(angle_t a, angle_t t);
    int unsigned ar;
    int unsigned tr;
    int unsigned d;
    ar = a % FULL_TURN;
    tr = t % FULL_TURN;
    d = (ar >= tr) ? ar - tr : ar + FULL_TURN - tr;
    return (d < FULL_TURN - d) ? d : FULL_TURN - d;
  endfunction

  function automatic void score_candidate(cand_t c);
    search_result_t r;
    int unsigned total;
    int unsigned slot;
    total = 0;
    for (int i = 0; i < ACTIVE_LANES; i++) total += wrapped_gap(c.ang[i], target_vec[i]);
    // index sticks at the top slot once the search runs long
    if (seen_count >= MAX_CANDIDATES_DEF) begin
      slot = MAX_CANDIDATES_DEF - 1;
      count_saturated = 1'b1;
    end else begin
      slot = seen_count;
      seen_count++;
    end
    // strict compare: ties keep the earlier candidate
    if (!have_winner || total < best_total) begin
      have_winner = 1'b1;
      best_total = total;
      winner_slot = slot;
      winner_vec = c.ang;
    end
    if (c.last) begin
      r.index = INDEX_W'(winner_slot);
      r.distance = DIST_W'(best_total);
      r.angles = winner_vec;
      r.overflow = count_saturated;
      results_due.push_back(r);
      restart_search();
    end
  endfunction

  task automatic log_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("[cycle %0d] mismatch: %s", cycle_count, what);
  endtask

  // gap length for either side: mostly none, often short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // ---- driver: one word in flight, held steady while stalled ----
  always @(posedge clk) begin : feed
    static int unsigned send_gap = 0;
    cand_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (word_q.size() != 0) begin
        w = word_q.pop_front();
        in_angle_0 <= w.ang[0];
        in_angle_1 <= w.ang[1];
        in_angle_2 <= w.ang[2];
        in_angle_3 <= w.ang[3];
        in_angle_4 <= w.ang[4];
        in_angle_5 <= w.ang[5];
        in_last <= w.last;
        in_valid <= 1'b1;
        send_gap = idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // every accepted word goes through the model
  always @(posedge clk) begin : predict
    cand_t c;
    if (rst_n && in_valid && !in_stall) begin
      c.ang = {in_angle_5, in_angle_4, in_angle_3, in_angle_2, in_angle_1, in_angle_0};
      c.last = in_last;
      score_candidate(c);
    end
  end

  // ---- receiver: random stalls, plus one long hold-off to back the block up ----
  always @(posedge clk) begin : sink
    static int unsigned hold_left = 0;
    int unsigned stall_len;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (pressure_on && !pressure_done) begin
      hold_left = LONG_HOLD - 1;
      pressure_done = 1'b1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      stall_len = idle_len();
      out_stall <= (stall_len != 0);
      hold_left = (stall_len != 0) ? stall_len - 1 : 0;
    end
  end

  // ---- monitor: each result word against the oldest prediction ----
  always @(posedge clk) begin : check
    search_result_t e;
    angle_vec_t got;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        log_mismatch($sformatf("result word with none expected, index %0d", out_best_index));
      end else begin
        e = results_due.pop_front();
        got = {out_best_angle_5, out_best_angle_4, out_best_angle_3,
               out_best_angle_2, out_best_angle_1, out_best_angle_0};
        if (out_best_index !== e.index)
          log_mismatch($sformatf("best_index got %0d want %0d", out_best_index, e.index));
        if (out_best_distance !== e.distance)
          log_mismatch($sformatf("best_distance got %0d want %0d",
                                 out_best_distance, e.distance));
        for (int i = 0; i < LANES; i++)
          if (got[i] !== e.angles[i])
            log_mismatch($sformatf("best_angle_%0d got %0d want %0d", i, got[i], e.angles[i]));
        if (out_index_overflow !== e.overflow)
          log_mismatch($sformatf("index_overflow got %0b want %0b",
                                 out_index_overflow, e.overflow));
      end
    end
  end

  // ---- run guard ----
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---- stimulus helpers ----
  task automatic queue_word(angle_t a0, angle_t a1, angle_t a2, angle_t a3, angle_t a4,
                            angle_t a5, logic last);
    cand_t c;
    c.ang = {a5, a4, a3, a2, a1, a0};
    c.last = last;
    word_q.push_back(c);
  endtask

  // register writes only happen with the block idle
  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, angle_t data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx <= CFG_TARGET_LAST) target_vec[idx - CFG_TARGET_0] = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_targets(angle_t t0, angle_t t1, angle_t t2, angle_t t3, angle_t t4,
                               angle_t t5);
    angle_vec_t v;
    v = {t5, t4, t3, t2, t1, t0};
    for (int i = 0; i < LANES; i++) write_register(CFG_INDEX_W'(CFG_TARGET_0 + i), v[i]);
  endtask

  // drain: nothing queued, nothing on the wire, nothing owed, then pause before
  // touching the registers again
  task automatic wait_idle();
    while (word_q.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic angle_t pick_target();
    case ($urandom_range(0, 7))
      0: return angle_t'(0);
      1: return angle_t'(FULL_TURN - 1);
      2: return angle_t'(FULL_TURN);
      3: return angle_t'(ANGLE_TOP);
      default: return angle_t'($urandom_range(0, ANGLE_TOP));
    endcase
  endfunction

  // candidate angles: mostly in range, some past a full turn, some hugging
  // the target so that close races and wraparound show up
  function automatic angle_t pick_angle(angle_t tgt);
    int unsigned r;
    int unsigned t;
    r = $urandom_range(0, 99);
    t = tgt % FULL_TURN;
    if (r < 55) return angle_t'($urandom_range(0, FULL_TURN - 1));
    if (r < 72) return angle_t'($urandom_range(FULL_TURN, ANGLE_TOP));
    if (r < 90) return angle_t'((t + FULL_TURN + $urandom_range(0, 64) - 32) % FULL_TURN);
    case ($urandom_range(0, 3))
      0: return angle_t'(0);
      1: return angle_t'(FULL_TURN - 1);
      2: return angle_t'(ANGLE_TOP);
      default: return tgt;
    endcase
  endfunction

  // searches of random length; some words repeat the previous one to force ties
  task automatic random_searches(int unsigned n_words, int unsigned max_len);
    cand_t c;
    int unsigned left_in_search;
    left_in_search = 0;
    for (int unsigned n = 0; n < n_words; n++) begin
      if (left_in_search == 0) left_in_search = $urandom_range(1, max_len);
      if (n == 0 || left_in_search == 1 || $urandom_range(0, 9) != 0)
        for (int i = 0; i < LANES; i++) c.ang[i] = pick_angle(target_vec[i]);
      left_in_search--;
      c.last = (left_in_search == 0) || (n == n_words - 1);
      if (c.last) left_in_search = 0;
      word_q.push_back(c);
    end
  endtask

  task automatic long_search(int unsigned len);
    cand_t c;
    for (int unsigned n = 0; n < len; n++) begin
      for (int i = 0; i < LANES; i++) c.ang[i] = pick_angle(target_vec[i]);
      c.last = (n == len - 1);
      word_q.push_back(c);
    end
  endtask

  // ---- test sequence ----
  initial begin
    restart_search();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // targets at reset value zero: range edges and the folding of big angles
    queue_word(0, 0, 0, 0, 0, 0, 1'b1);
    queue_word(23039, 23039, 23039, 23039, 23039, 23039, 1'b1);
    queue_word(11520, 11520, 11520, 11520, 11520, 11520, 1'b1);  // farthest point
    queue_word(23040, 23040, 23040, 23040, 23040, 23040, 1'b1);  // one full turn
    queue_word(32767, 32767, 32767, 32767, 32767, 32767, 1'b1);
    queue_word(15'h5555, 15'h2AAA, 15'h5555, 15'h2AAA, 15'h4000, 15'h3FFF, 1'b1);
    // tie on the second and third word: the second one must win
    queue_word(11520, 11520, 11520, 11520, 11520, 11520, 1'b0);
    queue_word(100, 100, 100, 100, 100, 100, 1'b0);
    queue_word(100, 100, 100, 100, 100, 100, 1'b0);
    queue_word(5000, 5000, 5000, 5000, 5000, 5000, 1'b1);
    // tie right on the first word
    queue_word(0, 0, 0, 0, 0, 0, 1'b0);
    queue_word(0, 0, 0, 0, 0, 0, 1'b1);
    // each word strictly closer than the one before
    queue_word(9000, 9000, 9000, 9000, 9000, 9000, 1'b0);
    queue_word(4000, 20000, 4000, 20000, 4000, 20000, 1'b0);
    queue_word(1, 23039, 1, 23039, 1, 23039, 1'b1);
    wait_idle();

    // targets at the top of the range: small angles wrap to distance one
    write_targets(23039, 23039, 23039, 23039, 23039, 23039);
    queue_word(0, 0, 0, 0, 0, 0, 1'b1);
    queue_word(23039, 23039, 23039, 23039, 23039, 23039, 1'b1);
    queue_word(11519, 11520, 11521, 0, 23039, 32767, 1'b1);
    wait_idle();

    // targets past a full turn, and writes to the unused slots
    write_targets(32767, 32767, 32767, 32767, 32767, 32767);
    write_register(CFG_SPARE_6, 15'h7FFF);
    write_register(CFG_SPARE_7, 15'h1234);
    queue_word(9727, 9727, 9727, 9727, 9727, 9727, 1'b1);
    queue_word(0, 0, 0, 0, 0, 0, 1'b1);
    queue_word(32767, 0, 32767, 0, 32767, 0, 1'b1);
    wait_idle();

    // right at the candidate limit, then past it so the index saturates
    write_targets(pick_target(), pick_target(), pick_target(), pick_target(),
                  pick_target(), pick_target());
    long_search(MAX_CANDIDATES_DEF);
    long_search(MAX_CANDIDATES_DEF + 4);
    wait_idle();

    // random phases, one of them with no idling on either side
    for (int p = 0; p < 6; p++) begin
      write_targets(pick_target(), pick_target(), pick_target(), pick_target(),
                    pick_target(), pick_target());
      if ($urandom_range(0, 1) != 0) write_register(CFG_SPARE_6, pick_target());
      no_idle = (p == 2);
      random_searches(45, 12);
      wait_idle();
    end

    // short searches at full rate while the receiver holds off: the output
    // register fills and the block must stall its input
    write_targets(pick_target(), pick_target(), pick_target(), pick_target(),
                  pick_target(), pick_target());
    no_idle = 1'b1;
    random_searches(40, 3);
    pressure_on = 1'b1;
    wait_idle();
    no_idle = 1'b0;
    pressure_on = 1'b0;

    repeat (10) @(posedge clk);
    if (results_due.size() != 0)
      log_mismatch($sformatf("%0d expected results never arrived", results_due.size()));
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
